### sv/dtt_pkg.sv
// Shared types, widths and constants for the daily temperature-range transmissivity block.
package dtt_pkg;

    localparam int TEMP_W   = 12;            // temperature, 1/16 degC, signed
    localparam int COEFF_W  = 16;            // coefficient, unsigned Q0.16
    localparam int HFRAC_W  = 6;             // samples per hour
    localparam int COUNT_W  = 11;            // valid-sample counter
    localparam int OUT_W    = 20;            // transmissivity, unsigned Q4.16
    localparam int MUL_A_W  = 32;            // shared multiplier, wide operand
    localparam int MUL_B_W  = 16;            // shared multiplier, narrow operand
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int RAD_W    = 44;            // coeff^2 * range
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int STEP_W   = $clog2(ROOT_W);

    localparam int S_TDATA_W = 40;           // three temperatures, padded to bytes
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 24;           // transmissivity, padded to bytes
    localparam int M_TUSER_W = 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd11141;
    localparam logic [HFRAC_W-1:0] HFRAC_RESET = 6'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMANI_COEFF    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOURLY_FRACTION = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_CC,
        S_MUL_CD,
        S_START,
        S_ROOT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_sqrt_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

endpackage

### sv/daily_trange_transmissivity_top.sv
// Daily temperature-range transmissivity: day tracking, shared multiplier and root sequencer.
// An item without tlast is absorbed in its accept cycle, one per clock while idle.
// An item with tlast starts a result run: two passes through the shared 32x16 multiplier,
// a start step, the bit-serial square root, and S_DONE, which waits for a free output.
// s_tready stays low for that run, so no new item is taken until the sequencer is idle.
// Reset (synchronous, active low) clears day state, sequencer and output valid and
// restores both configuration registers to their default values.
module daily_trange_transmissivity_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Sample stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [11:0] temp_sample, [23:12] day_min, [35:24] day_max, [39:36] zero
    input  logic [dtt_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [0] sample_valid, [1] day_min_valid, [2] day_max_valid, [3] now_valid,
    // [4] first_of_day
    input  logic [dtt_pkg::S_TUSER_W-1:0]  i_s_tuser,
    input  logic                           i_s_tlast,    // last_of_day
    // Result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [19:0] transmissivity, [23:20] zero
    output logic [dtt_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // [0] has_value
    output logic [dtt_pkg::M_TUSER_W-1:0]  o_m_tuser,
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dtt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dtt_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import dtt_pkg::*;

    // ---------------------------------------------------------------
    // Configuration: coefficient and the sample-count threshold, which
    // is kept premultiplied (20 * samples per hour) for the day logic.
    // ---------------------------------------------------------------
    logic [COEFF_W-1:0] r_coeff;
    logic [COUNT_W-1:0] r_thresh;
    logic [COUNT_W-1:0] thresh_wr;

    assign o_cfg_ready = 1'b1;
    assign thresh_wr = ({{(COUNT_W-HFRAC_W){1'b0}}, i_cfg_data[HFRAC_W-1:0]} << 4)
                     + ({{(COUNT_W-HFRAC_W){1'b0}}, i_cfg_data[HFRAC_W-1:0]} << 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff  <= COEFF_RESET;
            r_thresh <= COUNT_W'(20 * HFRAC_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SAMANI_COEFF:    r_coeff  <= i_cfg_data[COEFF_W-1:0];
                REG_HOURLY_FRACTION: r_thresh <= thresh_wr;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Request fields
    // ---------------------------------------------------------------
    logic signed [TEMP_W-1:0] in_sample, in_dmin, in_dmax;
    logic in_svalid, in_dmin_v, in_dmax_v, in_now_v, in_first;
    logic s_acc;

    assign in_sample = i_s_tdata[TEMP_W-1:0];
    assign in_dmin   = i_s_tdata[2*TEMP_W-1:TEMP_W];
    assign in_dmax   = i_s_tdata[3*TEMP_W-1:2*TEMP_W];
    assign in_svalid = i_s_tuser[0];
    assign in_dmin_v = i_s_tuser[1];
    assign in_dmax_v = i_s_tuser[2];
    assign in_now_v  = i_s_tuser[3];
    assign in_first  = i_s_tuser[4];

    // ---------------------------------------------------------------
    // Day tracking state
    // ---------------------------------------------------------------
    logic signed [TEMP_W-1:0] r_run_min, r_run_max;
    logic                     r_min_present, r_max_present;
    logic [COUNT_W-1:0]       r_valid_count;
    logic                     r_daily_mode, r_fallback_on;

    logic signed [TEMP_W-1:0] n_run_min, n_run_max;
    logic                     n_min_present, n_max_present;
    logic [COUNT_W-1:0]       n_valid_count;
    logic                     n_daily_mode, n_fallback_on;
    logic                     day_ok, day_inv;
    logic [TEMP_W-1:0]        day_diff;

    always_comb begin
        n_run_min     = r_run_min;
        n_run_max     = r_run_max;
        n_min_present = r_min_present;
        n_max_present = r_max_present;
        n_valid_count = r_valid_count;
        n_daily_mode  = r_daily_mode;
        n_fallback_on = r_fallback_on;

        // Restart tracking on the first request of a day.
        if (in_first) begin
            n_valid_count = '0;
            n_daily_mode  = in_dmin_v && in_dmax_v;
            n_fallback_on = !(in_dmin_v && in_dmax_v) && in_now_v;
            n_min_present = in_dmin_v;
            n_max_present = in_dmax_v;
            n_run_min     = in_dmin_v ? in_dmin : '0;
            n_run_max     = in_dmax_v ? in_dmax : '0;
        end

        // In fallback mode, fold a valid sample into the running range and count it.
        if (n_fallback_on && in_svalid) begin
            if (!n_min_present || in_sample < n_run_min) n_run_min = in_sample;
            if (!n_max_present || in_sample > n_run_max) n_run_max = in_sample;
            n_min_present = 1'b1;
            n_max_present = 1'b1;
            if (n_valid_count != COUNT_MAX) n_valid_count = n_valid_count + 1'b1;
        end

        day_ok   = n_daily_mode ||
                   (n_fallback_on && n_min_present && n_max_present &&
                    n_valid_count > r_thresh);
        day_inv  = n_run_min > n_run_max;
        // Range fits the field width whenever it is not inverted.
        day_diff = TEMP_W'(n_run_max - n_run_min);

        // Close the day.
        if (i_s_tlast) begin
            n_daily_mode  = 1'b0;
            n_fallback_on = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_min     <= '0;
            r_run_max     <= '0;
            r_min_present <= 1'b0;
            r_max_present <= 1'b0;
            r_valid_count <= '0;
            r_daily_mode  <= 1'b0;
            r_fallback_on <= 1'b0;
        end else if (s_acc) begin
            r_run_min     <= n_run_min;
            r_run_max     <= n_run_max;
            r_min_present <= n_min_present;
            r_max_present <= n_max_present;
            r_valid_count <= n_valid_count;
            r_daily_mode  <= n_daily_mode;
            r_fallback_on <= n_fallback_on;
        end
    end

    // ---------------------------------------------------------------
    // Result sequencer: coeff*coeff, then *range, then square root.
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    logic                r_has_value;      // range found this day
    logic                r_zero;           // force transmissivity to zero
    logic [TEMP_W-1:0]   r_diff;
    logic [RAD_W-1:0]    r_prod;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_p;
    logic                prod_ld;
    logic                out_ld;

    t_sqrt_ctl           sqrt_ctl;
    t_sqrt_stat          sqrt_stat;
    logic [ROOT_W-1:0]   sqrt_root;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_t;
    logic                r_out_hv;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // One shared multiplier; its operands follow the sequencer step.
    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    always_comb begin
        n_state      = r_state;
        mul_a        = {{(MUL_A_W-COEFF_W){1'b0}}, r_coeff};
        mul_b        = r_coeff;
        prod_ld      = 1'b0;
        out_ld       = 1'b0;
        sqrt_ctl     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && i_s_tlast) n_state = S_MUL_CC;
            end
            S_MUL_CC: begin
                prod_ld = 1'b1;
                n_state = S_MUL_CD;
            end
            S_MUL_CD: begin
                mul_a   = r_prod[MUL_A_W-1:0];
                mul_b   = {{(MUL_B_W-TEMP_W){1'b0}}, r_diff};
                prod_ld = 1'b1;
                n_state = S_START;
            end
            S_START: begin
                sqrt_ctl.start = 1'b1;
                n_state        = S_ROOT;
            end
            S_ROOT: begin
                if (sqrt_stat.done) n_state = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_m_tready) begin
                    out_ld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Snapshot the day's outcome on the closing request.
    always_ff @(posedge i_clk) begin
        if (s_acc && i_s_tlast) begin
            r_has_value <= day_ok;
            r_zero      <= !day_ok || day_inv;
            r_diff      <= day_diff;
        end
        if (prod_ld) begin
            r_prod <= mul_p[RAD_W-1:0];
        end
    end

    dtt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sqrt_ctl),
        .i_rad   (r_prod),
        .o_stat  (sqrt_stat),
        .o_root  (sqrt_root)
    );

    // ---------------------------------------------------------------
    // Output register; root >> 2 always fits the Q4.16 field.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_out_t  <= r_zero ? '0 : sqrt_root[ROOT_W-1:2];
            r_out_hv <= r_has_value;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, r_out_t};
    assign o_m_tuser  = r_out_hv;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_idle_root_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !sqrt_stat.busy)
        else $error("square root busy while taking requests");

    a_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_stat.done |-> (r_state == S_ROOT))
        else $error("square root finished outside its wait step");

    a_no_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("result without range carries nonzero transmissivity");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast) |=> (r_state == S_MUL_CC))
        else $error("closing request did not start the result run");

endmodule

### sv/dtt_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module dtt_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dtt_pkg::t_sqrt_ctl        i_ctl,
    input  logic [dtt_pkg::RAD_W-1:0] i_rad,
    output dtt_pkg::t_sqrt_stat       o_stat,
    output logic [dtt_pkg::ROOT_W-1:0] o_root
);
    import dtt_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RAD_W-1:0]  r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {r_rem[REM_W-3:0], r_x[RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[RAD_W-3:0], 2'b00};
            r_rem  <= take ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], take};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

endmodule
